@@ sv/sobm_pkg.sv @@
`timescale 1ns / 1ps
// Package for the small-object bitmap allocator.
// Holds field widths, command and status codes and the sequencer state type.
// No dependencies.
package sobm_pkg;

   localparam int ADDR_W   = 32;
   localparam int SLOT_W   = 11;
   localparam int COUNT_W  = 12;

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_MARK  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_SWEEP = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      STS_DONE         = 2'd0,
      STS_NO_SPACE     = 2'd1,
      STS_OUT_OF_RANGE = 2'd2,
      STS_REJECTED     = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_ALLOC_SCAN,
      S_ALLOC_ADDR,
      S_MARK_ALIGN,
      S_MARK_CHECK,
      S_CLEAR,
      S_SWEEP,
      S_RESP
   } state_type;

endpackage

@@ sv/sobm_req_if.sv @@
`timescale 1ns / 1ps
// Request channel of the allocator: command and candidate address.
// Depends on sobm_pkg.
interface sobm_req_if;
   import sobm_pkg::*;

   logic              valid;
   logic              ready;
   command_type       command;
   logic [ADDR_W-1:0] addr;

   modport source (output valid, output command, output addr, input ready);
   modport sink   (input valid, input command, input addr, output ready);

endinterface

@@ sv/sobm_rsp_if.sv @@
`timescale 1ns / 1ps
// Response channel of the allocator: status, slot, object address, freed count.
// Depends on sobm_pkg.
interface sobm_rsp_if;
   import sobm_pkg::*;

   logic               valid;
   logic               ready;
   status_type         status;
   logic [SLOT_W-1:0]  slot;
   logic [ADDR_W-1:0]  obj_addr;
   logic [COUNT_W-1:0] freed_count;

   modport source (output valid, output status, output slot, output obj_addr,
                   output freed_count, input ready);
   modport sink   (input valid, input status, input slot, input obj_addr,
                   input freed_count, output ready);

endinterface

@@ sv/sobm_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sobm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/sobm_divider.sv @@
`timescale 1ns / 1ps
// Split of a value by a constant power of two: shift for the quotient, mask for the remainder.
// Depends on sobm_pkg.
module sobm_divider #(
   parameter int DIVISOR = 32
) (
   input  logic [sobm_pkg::ADDR_W-1:0] dividend,
   output logic [sobm_pkg::ADDR_W-1:0] quotient,
   output logic [sobm_pkg::ADDR_W-1:0] remainder
);
   import sobm_pkg::*;

   localparam int SHIFT = $clog2(DIVISOR);

   assign quotient  = dividend >> SHIFT;
   assign remainder = dividend & ADDR_W'(DIVISOR - 1);

endmodule

@@ sv/sobm_word_unit.sv @@
`timescale 1ns / 1ps
// Per-word bitmap logic: full test, lowest free bit, dead slots and their count.
// No dependencies.
module sobm_word_unit #(
   parameter int WORD_BITS = 32
) (
   input  logic [WORD_BITS-1:0]             alloc_word,
   input  logic [WORD_BITS-1:0]             mark_word,
   output logic                             full,
   output logic [$clog2(WORD_BITS)-1:0]     free_bit,
   output logic [WORD_BITS-1:0]             dead,
   output logic [$clog2(WORD_BITS+1)-1:0]   dead_count
);

   localparam int BIW = $clog2(WORD_BITS);
   localparam int PCW = $clog2(WORD_BITS + 1);
   localparam int LV  = $clog2(WORD_BITS);
   localparam int PAD = 2 ** LV;

   logic [PAD-1:0] dead_pad;
   logic [PCW-1:0] sums [LV+1][PAD];

   assign full     = &alloc_word;
   assign dead     = alloc_word & ~mark_word;
   assign dead_pad = PAD'(dead);

   always_comb begin
      free_bit = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!alloc_word[i]) begin
            free_bit = BIW'(i);
         end
      end
   end

   // population count as a balanced adder tree
   always_comb begin
      for (int l = 0; l <= LV; l++) begin
         for (int i = 0; i < PAD; i++) begin
            sums[l][i] = '0;
         end
      end
      for (int i = 0; i < PAD; i++) begin
         sums[0][i] = PCW'(dead_pad[i]);
      end
      for (int l = 0; l < LV; l++) begin
         for (int i = 0; i < (PAD >> (l + 1)); i++) begin
            sums[l+1][i] = sums[l][2*i] + sums[l][2*i+1];
         end
      end
   end

   assign dead_count = sums[LV][0];

endmodule

@@ sv/small_object_bitmap_allocator.sv @@
`timescale 1ns / 1ps
// Small-object slot allocator with allocation and mark bitmaps for a mark-sweep heap.
// Top level; depends on sobm_pkg, sobm_req_if, sobm_rsp_if, sobm_ram, sobm_divider,
// sobm_word_unit.
//
// One item at a time. Both bitmaps sit in RAMs of NUM_SLOTS/WORD_BITS words, read
// one word per cycle. After reset a clearing pass over every word zeroes both bitmaps;
// no item is taken until it ends, heap_base writes are taken throughout.
// Alloc walks the words from the saved next-fit word; sweep and clear-marks walk every word.
// Mark aligns the address and splits the slot index into word and bit with masks and
// shifts, so OBJ_BYTES and WORD_BITS must be powers of two; the block does not check
// this. The result waits in an output register, and the next item is accepted while it
// waits; a new result is held back until the old one is taken.
module small_object_bitmap_allocator #(
   parameter int NUM_SLOTS = 2048,
   parameter int WORD_BITS = 32,
   parameter int OBJ_BYTES = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [sobm_pkg::ADDR_W-1:0] csr_write_data,
   sobm_req_if.sink                    req_ch,
   sobm_rsp_if.source                  rsp_ch
);
   import sobm_pkg::*;

   localparam int NUM_WORDS = NUM_SLOTS / WORD_BITS;
   localparam int WAW       = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
   localparam int SW        = $clog2(NUM_SLOTS);
   localparam int CW        = $clog2(NUM_SLOTS + 1);
   localparam int BIW       = $clog2(WORD_BITS);
   localparam int PCW       = $clog2(WORD_BITS + 1);
   localparam int OLOG      = $clog2(OBJ_BYTES);

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   hb_ff, hb_in;
   logic [WAW-1:0]      nfw_ff, nfw_in;
   logic [WAW-1:0]      ptr_ff, ptr_in;
   logic [WAW-1:0]      prev_ff, prev_in;
   logic [WAW-1:0]      chk_ff, chk_in;
   logic                dv_ff, dv_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   status_type          status_ff, status_in;
   logic [SW-1:0]       slot_ff, slot_in;
   logic [ADDR_W-1:0]   obj_ff, obj_in;
   logic [CW-1:0]       freed_ff, freed_in;
   logic [WAW-1:0]      word_ff, word_in;
   logic [BIW-1:0]      bit_ff, bit_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [ADDR_W-1:0]   rsp_obj_ff, rsp_obj_in;
   logic [COUNT_W-1:0]  rsp_freed_ff, rsp_freed_in;

   logic                 accept;
   logic                 rsp_free;
   logic                 last_chk;
   logic                 last_ptr;
   logic [WAW-1:0]       ptr_next;
   logic                 alloc_hit;
   logic                 mark_ok;
   logic [ADDR_W-1:0]    aligned;
   logic [ADDR_W-1:0]    mark_diff;
   logic [ADDR_W-1:0]    mark_idx;
   logic [ADDR_W-1:0]    word_q;
   logic [ADDR_W-1:0]    bit_r;
   logic                 below_base;
   logic                 idx_over;
   logic                 mark_range;

   logic                 alloc_we, mark_we;
   logic [WAW-1:0]       alloc_wa, mark_wa, rd_addr;
   logic [WORD_BITS-1:0] alloc_wd, mark_wd, alloc_rd, mark_rd;

   logic                 wu_full;
   logic [BIW-1:0]       wu_free_bit;
   logic [WORD_BITS-1:0] wu_dead;
   logic [PCW-1:0]       wu_dead_count;

   sobm_ram #(.WIDTH(WORD_BITS), .DEPTH(NUM_WORDS)) u_alloc_ram (
      .clock   (clock),
      .wr_en   (alloc_we),
      .wr_addr (alloc_wa),
      .wr_data (alloc_wd),
      .rd_addr (rd_addr),
      .rd_data (alloc_rd)
   );

   sobm_ram #(.WIDTH(WORD_BITS), .DEPTH(NUM_WORDS)) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (mark_wa),
      .wr_data (mark_wd),
      .rd_addr (rd_addr),
      .rd_data (mark_rd)
   );

   sobm_divider #(.DIVISOR(WORD_BITS)) u_divider (
      .dividend  (mark_idx),
      .quotient  (word_q),
      .remainder (bit_r)
   );

   sobm_word_unit #(.WORD_BITS(WORD_BITS)) u_word_unit (
      .alloc_word (alloc_rd),
      .mark_word  (mark_rd),
      .full       (wu_full),
      .free_bit   (wu_free_bit),
      .dead       (wu_dead),
      .dead_count (wu_dead_count)
   );

   assign accept     = req_ch.valid && req_ch.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ch.ready;
   assign last_chk   = chk_ff == WAW'(NUM_WORDS - 1);
   assign last_ptr   = ptr_ff == WAW'(NUM_WORDS - 1);
   assign ptr_next   = last_ptr ? '0 : ptr_ff + 1'b1;
   assign alloc_hit  = dv_ff && !wu_full;
   assign mark_ok    = alloc_rd[bit_ff] && !mark_rd[bit_ff];
   assign aligned    = addr_ff & ~ADDR_W'(OBJ_BYTES - 1);
   assign mark_diff  = aligned - hb_ff;
   assign mark_idx   = mark_diff >> OLOG;
   assign below_base = aligned < hb_ff;
   assign idx_over   = mark_idx >= ADDR_W'(NUM_SLOTS);
   assign mark_range = below_base || idx_over;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT: begin
            if (last_ptr) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               unique case (req_ch.command)
                  CMD_ALLOC: state_in = S_ALLOC_SCAN;
                  CMD_MARK:  state_in = S_MARK_ALIGN;
                  CMD_CLEAR: state_in = S_CLEAR;
                  CMD_SWEEP: state_in = S_SWEEP;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_ALLOC_SCAN: begin
            if (alloc_hit) state_in = S_ALLOC_ADDR;
            else if (dv_ff && last_chk) state_in = S_RESP;
         end
         S_ALLOC_ADDR: state_in = S_RESP;
         S_MARK_ALIGN: state_in = mark_range ? S_RESP : S_MARK_CHECK;
         S_MARK_CHECK: state_in = S_RESP;
         S_CLEAR: begin
            if (last_ptr) state_in = S_RESP;
         end
         S_SWEEP: begin
            if (dv_ff && last_chk) state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_INIT;
      endcase
   end

   // sequencer outputs: RAM ports, request ready
   always_comb begin
      req_ch.ready = state_ff == S_IDLE;
      rd_addr      = (state_ff == S_MARK_ALIGN) ? WAW'(word_q) : ptr_ff;
      alloc_we     = 1'b0;
      alloc_wa     = prev_ff;
      alloc_wd     = '0;
      mark_we      = 1'b0;
      mark_wa      = ptr_ff;
      mark_wd      = '0;
      unique case (state_ff)
         S_INIT: begin
            alloc_we = 1'b1;
            alloc_wa = ptr_ff;
            mark_we  = 1'b1;
         end
         S_ALLOC_SCAN: begin
            alloc_we = alloc_hit;
            alloc_wd = alloc_rd | (WORD_BITS'(1) << wu_free_bit);
         end
         S_MARK_CHECK: begin
            mark_we = mark_ok;
            mark_wa = word_ff;
            mark_wd = mark_rd | (WORD_BITS'(1) << bit_ff);
         end
         S_CLEAR: begin
            mark_we = 1'b1;
         end
         S_SWEEP: begin
            alloc_we = dv_ff;
            alloc_wd = alloc_rd & ~wu_dead;
         end
         default: begin
         end
      endcase
   end

   // datapath registers
   always_comb begin
      hb_in         = csr_write_enable ? csr_write_data : hb_ff;
      nfw_in        = nfw_ff;
      ptr_in        = ptr_ff;
      prev_in       = ptr_ff;
      chk_in        = chk_ff;
      dv_in         = 1'b0;
      addr_in       = addr_ff;
      status_in     = status_ff;
      slot_in       = slot_ff;
      obj_in        = obj_ff;
      freed_in      = freed_ff;
      word_in       = word_ff;
      bit_in        = bit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_obj_in    = rsp_obj_ff;
      rsp_freed_in  = rsp_freed_ff;
      unique case (state_ff)
         S_INIT, S_CLEAR: begin
            ptr_in = ptr_next;
         end
         S_IDLE: begin
            addr_in   = req_ch.addr;
            status_in = STS_DONE;
            slot_in   = '0;
            obj_in    = '0;
            freed_in  = '0;
            chk_in    = '0;
            ptr_in    = (req_ch.command == CMD_ALLOC) ? nfw_ff : '0;
         end
         S_ALLOC_SCAN: begin
            ptr_in = ptr_next;
            dv_in  = 1'b1;
            if (dv_ff) chk_in = chk_ff + 1'b1;
            if (alloc_hit) begin
               nfw_in  = prev_ff;
               slot_in = SW'(ADDR_W'(prev_ff) * ADDR_W'(WORD_BITS) + ADDR_W'(wu_free_bit));
            end else if (dv_ff && last_chk) begin
               status_in = STS_NO_SPACE;
            end
         end
         S_ALLOC_ADDR: begin
            obj_in = hb_ff + ADDR_W'(ADDR_W'(slot_ff) * ADDR_W'(OBJ_BYTES));
         end
         S_MARK_ALIGN: begin
            if (mark_range) begin
               status_in = STS_OUT_OF_RANGE;
            end else begin
               slot_in = SW'(mark_idx);
               word_in = WAW'(word_q);
               bit_in  = BIW'(bit_r);
            end
         end
         S_MARK_CHECK: begin
            if (!mark_ok) status_in = STS_REJECTED;
         end
         S_SWEEP: begin
            ptr_in = ptr_next;
            dv_in  = 1'b1;
            if (dv_ff) begin
               chk_in   = chk_ff + 1'b1;
               freed_in = freed_ff + CW'(wu_dead_count);
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_slot_in   = SLOT_W'(slot_ff);
               rsp_obj_in    = obj_ff;
               rsp_freed_in  = COUNT_W'(freed_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         hb_ff        <= '0;
         nfw_ff       <= '0;
         ptr_ff       <= '0;
         chk_ff       <= '0;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hb_ff        <= hb_in;
         nfw_ff       <= nfw_in;
         ptr_ff       <= ptr_in;
         chk_ff       <= chk_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prev_ff       <= prev_in;
      addr_ff       <= addr_in;
      status_ff     <= status_in;
      slot_ff       <= slot_in;
      obj_ff        <= obj_in;
      freed_ff      <= freed_in;
      word_ff       <= word_in;
      bit_ff        <= bit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_obj_ff    <= rsp_obj_in;
      rsp_freed_ff  <= rsp_freed_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.slot        = rsp_slot_ff;
   assign rsp_ch.obj_addr    = rsp_obj_ff;
   assign rsp_ch.freed_count = rsp_freed_ff;

endmodule

@@ verif/sobm_reply_checker.sv @@
`timescale 1ns / 1ps
// Reply checker for the small-object bitmap allocator: keeps its own bitmaps and heap base,
// predicts one reply per accepted item and compares replies in order.
// Depends on sobm_pkg, sobm_req_if and sobm_rsp_if.
module sobm_reply_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [sobm_pkg::ADDR_W-1:0] csr_write_data,
   sobm_req_if                         req_ch,
   sobm_rsp_if                         rsp_ch,
   output int                          error_count,
   output int                          pending_count
);
   import sobm_pkg::*;

   localparam int NUM_SLOTS   = 2048;
   localparam int WORD_BITS   = 32;
   localparam int OBJ_BYTES   = 8;
   localparam int NUM_WORDS   = NUM_SLOTS / WORD_BITS;

   typedef struct packed {
      status_type         status;
      logic [SLOT_W-1:0]  slot;
      logic [ADDR_W-1:0]  obj_addr;
      logic [COUNT_W-1:0] freed_count;
   } heap_reply_type;

   logic [WORD_BITS-1:0] alloc_bits [NUM_WORDS];
   logic [WORD_BITS-1:0] mark_bits  [NUM_WORDS];
   int unsigned          next_word;
   logic [ADDR_W-1:0]    base_addr;
   heap_reply_type       pending_replies [$];
   heap_reply_type       want;
   int                   fails;

   initial begin
      fails         = 0;
      error_count   = 0;
      pending_count = 0;
   end

   function automatic heap_reply_type apply_heap_command(input command_type cmd,
                                                         input logic [ADDR_W-1:0] a);
      heap_reply_type       r;
      int unsigned          w, b, k, idx, freed;
      logic [ADDR_W-1:0]    aligned;
      logic [WORD_BITS-1:0] dead;
      bit                   found;
      r = '0;
      case (cmd)
         CMD_ALLOC: begin
            w     = next_word;
            found = 1'b0;
            for (k = 0; k < NUM_WORDS && !found; k++) begin
               if (alloc_bits[w] != '1) begin
                  b = 0;
                  while (alloc_bits[w][b]) b++;
                  alloc_bits[w][b] = 1'b1;
                  next_word        = w;
                  idx              = w * WORD_BITS + b;
                  r.slot           = idx[SLOT_W-1:0];
                  r.obj_addr       = base_addr + idx * OBJ_BYTES;
                  found            = 1'b1;
               end else begin
                  w = (w + 1) % NUM_WORDS;
               end
            end
            if (!found) r.status = STS_NO_SPACE;
         end
         CMD_MARK: begin
            aligned = a - (a % OBJ_BYTES);
            if (aligned < base_addr) begin
               r.status = STS_OUT_OF_RANGE;
            end else begin
               idx = (aligned - base_addr) / OBJ_BYTES;
               if (idx >= NUM_SLOTS) begin
                  r.status = STS_OUT_OF_RANGE;
               end else begin
                  r.slot = idx[SLOT_W-1:0];
                  w      = idx / WORD_BITS;
                  b      = idx % WORD_BITS;
                  if (!alloc_bits[w][b] || mark_bits[w][b]) r.status = STS_REJECTED;
                  else mark_bits[w][b] = 1'b1;
               end
            end
         end
         CMD_CLEAR: begin
            foreach (mark_bits[i]) mark_bits[i] = '0;
         end
         default: begin
            freed = 0;
            foreach (alloc_bits[i]) begin
               dead          = alloc_bits[i] & ~mark_bits[i];
               freed         = freed + $countones(dead);
               alloc_bits[i] = alloc_bits[i] & ~dead;
            end
            r.freed_count = freed[COUNT_W-1:0];
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (alloc_bits[i]) alloc_bits[i] = '0;
         foreach (mark_bits[i]) mark_bits[i] = '0;
         next_word = 0;
         base_addr = '0;
         pending_replies.delete();
      end else begin
         if (csr_write_enable) base_addr = csr_write_data;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_replies.size() == 0) begin
               fails++;
               $display("%0t: unexpected reply: expected none, got status %0d slot %0d obj %h freed %0d",
                        $time, rsp_ch.status, rsp_ch.slot, rsp_ch.obj_addr,
                        rsp_ch.freed_count);
            end else begin
               want = pending_replies.pop_front();
               if (rsp_ch.status !== want.status || rsp_ch.slot !== want.slot ||
                   rsp_ch.obj_addr !== want.obj_addr ||
                   rsp_ch.freed_count !== want.freed_count) begin
                  fails++;
                  $display({"%0t: reply mismatch: expected status %0d slot %0d obj %h freed %0d,",
                            " got status %0d slot %0d obj %h freed %0d"},
                           $time, want.status, want.slot, want.obj_addr,
                           want.freed_count, rsp_ch.status, rsp_ch.slot,
                           rsp_ch.obj_addr, rsp_ch.freed_count);
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            pending_replies.push_back(apply_heap_command(req_ch.command, req_ch.addr));
      end
      error_count   <= fails;
      pending_count <= pending_replies.size();
   end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the small-object bitmap allocator: directed items, then random
// traffic with bursty input and a stalling receiver.
// Depends on sobm_pkg, the channel interfaces, the allocator and sobm_reply_checker.
module tb;
   import sobm_pkg::*;

   localparam int NUM_SLOTS    = 2048;
   localparam int OBJ_BYTES    = 8;
   localparam int RANDOM_ITEMS = 680;
   localparam int PHASE_ITEMS  = 170;
   localparam int DRAIN_CYCLES = 150;
   localparam int HOLD_CYCLES  = 400;

   logic              clock;
   logic              reset;
   logic              csr_write_enable;
   logic [ADDR_W-1:0] csr_write_data;
   int                error_count;
   int                pending_count;
   logic [ADDR_W-1:0] cur_base;
   int                burst_left;
   bit                hold_request;

   sobm_req_if req_ch ();
   sobm_rsp_if rsp_ch ();

   small_object_bitmap_allocator u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch)
   );

   sobm_reply_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .error_count      (error_count),
      .pending_count    (pending_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #(25_000_000);
      $display("CHECKS FAILED");
      $finish;
   end

   // receiver: random stall pattern re-picked from four modes, plus one long hold-off on request
   initial begin
      int mode;
      int mode_left;
      mode      = 0;
      mode_left = 0;
      hold_request = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = 64;
            end
            mode_left--;
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ch.ready <= $urandom_range(0, 1);
               default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   task automatic send_item(input command_type cmd, input logic [ADDR_W-1:0] a);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      req_ch.valid   <= 1'b1;
      req_ch.command <= cmd;
      req_ch.addr    <= a;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      burst_left--;
   endtask

   task automatic wait_quiet();
      int guard;
      guard = 0;
      req_ch.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending_count != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_base(input logic [ADDR_W-1:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      cur_base = v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [ADDR_W-1:0] slot_addr(input int unsigned s);
      return cur_base + s * OBJ_BYTES + $urandom_range(0, OBJ_BYTES - 1);
   endfunction

   function automatic logic [ADDR_W-1:0] pick_mark_addr();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return slot_addr($urandom_range(0, 191));
      if (r < 70) return slot_addr($urandom_range(0, NUM_SLOTS - 1));
      if (r < 85) return $urandom;
      if (r < 92) return cur_base - $urandom_range(1, OBJ_BYTES);
      return cur_base + NUM_SLOTS * OBJ_BYTES - OBJ_BYTES + $urandom_range(0, 2 * OBJ_BYTES - 1);
   endfunction

   function automatic logic [ADDR_W-1:0] pick_base();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         5: return $urandom;
         default: return $urandom & 32'h7FFF_FFF8;
      endcase
   endfunction

   initial begin
      int unsigned r;
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      req_ch.valid     <= 1'b0;
      req_ch.command   <= CMD_ALLOC;
      req_ch.addr      <= '0;
      cur_base   = '0;
      burst_left = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed, base zero
      write_base(32'h0);
      send_item(CMD_ALLOC, 32'h0);
      send_item(CMD_ALLOC, 32'hFFFF_FFFF);
      send_item(CMD_ALLOC, 32'h0);
      send_item(CMD_MARK, 32'h0);
      send_item(CMD_MARK, 32'h0);
      send_item(CMD_MARK, 32'h0000_000F);
      send_item(CMD_MARK, 32'h0000_0028);
      send_item(CMD_MARK, 32'h0000_4000);
      send_item(CMD_MARK, 32'h0000_3FFF);
      send_item(CMD_MARK, 32'hFFFF_FFFF);
      send_item(CMD_SWEEP, 32'h0);
      send_item(CMD_SWEEP, 32'h0);
      send_item(CMD_CLEAR, 32'hFFFF_FFFF);
      send_item(CMD_MARK, 32'h0000_0007);
      send_item(CMD_SWEEP, 32'hFFFF_FFFF);
      wait_quiet();

      // object address wraps past the top of memory
      write_base(32'hFFFF_FFF8);
      send_item(CMD_ALLOC, 32'h0);
      send_item(CMD_ALLOC, 32'h0);
      send_item(CMD_MARK, 32'hFFFF_FFF0);
      send_item(CMD_MARK, 32'hFFFF_FFFF);
      send_item(CMD_MARK, 32'h0000_000A);
      send_item(CMD_CLEAR, 32'h0);
      send_item(CMD_SWEEP, 32'h0);
      wait_quiet();

      write_base(32'hFFFF_FFFF);
      send_item(CMD_ALLOC, 32'h0);
      send_item(CMD_MARK, 32'hFFFF_FFFF);
      send_item(CMD_SWEEP, 32'h0);

      // random traffic
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % PHASE_ITEMS == 0) begin
            wait_quiet();
            write_base(pick_base());
         end
         if (i == 30) hold_request = 1'b1;
         r = $urandom_range(0, 99);
         if (r < 45) send_item(CMD_ALLOC, $urandom);
         else if (r < 80) send_item(CMD_MARK, pick_mark_addr());
         else if (r < 88) send_item(CMD_CLEAR, $urandom);
         else send_item(CMD_SWEEP, $urandom);
      end
      wait_quiet();

      if (error_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
